// ===== rtl/assert_macros.svh =====
// assertion macros included by the drive link responder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is active
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion, checked during reset too
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/dlr_pkg.sv =====
// types, constants and helper functions of the drive link responder
package dlr_pkg;

    localparam int BYTE_W  = 8;
    localparam int TYPE_W  = 4;
    localparam int CMD_W   = 11;
    localparam int POS_W   = 10;
    localparam int IDX_W   = 4;
    localparam int CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_END_BYTE   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_TYPE   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INFO_TYPE  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_CHK  = 8'd3;

    localparam logic [BYTE_W-1:0] END_BYTE_RST  = 8'hFF;
    localparam logic [TYPE_W-1:0] END_TYPE_RST  = 4'hF;
    localparam logic [TYPE_W-1:0] INFO_TYPE_RST = 4'h5;
    localparam logic [BYTE_W-1:0] START_CHK_RST = 8'h00;

    localparam logic [IDX_W-1:0] POWERUP_LAST = 4'd9;
    localparam logic [IDX_W-1:0] INFO_LAST    = 4'd8;

    localparam logic [BYTE_W-1:0] INFO_HEAD   = 8'h58;
    localparam logic [BYTE_W-1:0] INFO_POT    = 8'hC0;
    localparam logic [BYTE_W-1:0] INFO_STATUS = 8'h84;
    localparam logic [BYTE_W-1:0] INFO_MODE   = 8'h80;
    localparam logic [6:0]        INFO_SUM_FIXED = 7'h1C;

    typedef enum logic [1:0] {
        PKT_NONE,
        PKT_POWERUP,
        PKT_INFO
    } pkt_kind_t;

    function automatic logic [BYTE_W-1:0] powerup_byte(input logic [IDX_W-1:0] idx);
        logic [BYTE_W-1:0] b;
        case (idx)
            4'd0:    b = 8'h69;
            4'd1:    b = 8'h8A;
            4'd2:    b = 8'h89;
            4'd3:    b = 8'hDE;
            4'd4:    b = 8'hAD;
            4'd5:    b = 8'hC5;
            4'd6:    b = 8'hA5;
            4'd7:    b = 8'h81;
            default: b = 8'h8D;
        endcase
        return b;
    endfunction

    // offset by 512 and saturate to 1..1023
    function automatic logic [POS_W-1:0] to_pos(input logic signed [CMD_W-1:0] v);
        logic signed [CMD_W:0] t;
        logic [POS_W-1:0] r;
        t = {v[CMD_W-1], v} + 12'sd512;
        if (t < 12'sd1)
            r = 10'd1;
        else if (t > 12'sd1023)
            r = 10'd1023;
        else
            r = t[POS_W-1:0];
        return r;
    endfunction

endpackage

// ===== rtl/drive_link_responder.sv =====
// drive link responder: byte parser with power-up and general-info packet replies
// an accepted beat is held in the input beat register, then parsed; a reply packet is
// loaded into the packet serializer, which offers its first byte. A beat with no reply
// does not stall input; one that triggers a packet holds it until its last byte is sent
// reset: asynchronous active low, back to start-up phase with registers at defaults
module drive_link_responder (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [dlr_pkg::BYTE_W-1:0]          rx_byte,
    input  logic signed [dlr_pkg::CMD_W-1:0]    speed_cmd,
    input  logic signed [dlr_pkg::CMD_W-1:0]    steer_cmd,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [dlr_pkg::BYTE_W-1:0]          tx_byte,
    output logic                                last_of_packet,
    input  logic                                cfg_we,
    input  logic [dlr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dlr_pkg::BYTE_W-1:0]          cfg_data
);

`include "assert_macros.svh"

    logic [dlr_pkg::BYTE_W-1:0] end_byte_reg;
    logic [dlr_pkg::TYPE_W-1:0] end_type_reg;
    logic [dlr_pkg::TYPE_W-1:0] info_type_reg;
    logic [dlr_pkg::BYTE_W-1:0] start_chk_reg;

    logic                              in_full_reg;
    logic [dlr_pkg::BYTE_W-1:0]        rx_reg;
    logic signed [dlr_pkg::CMD_W-1:0]  speed_reg;
    logic signed [dlr_pkg::CMD_W-1:0]  steer_reg;

    logic                        running_reg, running_next;
    logic [dlr_pkg::BYTE_W-1:0]  prev_reg, prev_next;
    logic [dlr_pkg::TYPE_W-1:0]  type_reg, type_next;
    logic                        type_ok_reg, type_ok_next;

    dlr_pkg::pkt_kind_t          kind_reg, kind_next;
    logic [dlr_pkg::IDX_W-1:0]   idx_reg;
    logic [dlr_pkg::POS_W-1:0]   s_reg, d_reg, s_next, d_next;
    logic [6:0]                  chk_reg, chk_next;

    logic                        pkt_busy;
    logic [dlr_pkg::IDX_W-1:0]   last_idx;
    logic                        pkt_done;
    logic                        advance;
    logic                        in_accept;
    logic [6:0]                  mix7;

    assign pkt_busy  = (kind_reg != dlr_pkg::PKT_NONE);
    assign last_idx  = (kind_reg == dlr_pkg::PKT_POWERUP) ? dlr_pkg::POWERUP_LAST
                                                           : dlr_pkg::INFO_LAST;
    assign pkt_done  = pkt_busy && !out_stall && (idx_reg == last_idx);
    assign advance   = in_full_reg && (!pkt_busy || pkt_done);
    assign in_stall  = in_full_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    // parse one byte against the phase and type state
    always_comb
    begin
        running_next = running_reg;
        prev_next    = prev_reg;
        type_next    = type_reg;
        type_ok_next = type_ok_reg;
        kind_next    = dlr_pkg::PKT_NONE;
        s_next       = dlr_pkg::to_pos(speed_reg);
        d_next       = dlr_pkg::to_pos(steer_reg);
        mix7         = {1'b0, s_next[2:0], d_next[2:0]};
        chk_next     = ~(s_next[9:3] + d_next[9:3] + mix7 + dlr_pkg::INFO_SUM_FIXED);
        if (!running_reg)
        begin
            if (prev_reg == start_chk_reg && rx_reg == end_byte_reg)
            begin
                running_next = 1'b1;
                kind_next    = dlr_pkg::PKT_POWERUP;
            end
            else
            begin
                prev_next = rx_reg;
            end
        end
        else
        begin
            if (!rx_reg[7] && rx_reg[3:0] != end_type_reg)
            begin
                type_next    = rx_reg[3:0];
                type_ok_next = 1'b1;
            end
            if (rx_reg == end_byte_reg && type_ok_next && type_next == info_type_reg)
                kind_next = dlr_pkg::PKT_INFO;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            end_byte_reg  <= dlr_pkg::END_BYTE_RST;
            end_type_reg  <= dlr_pkg::END_TYPE_RST;
            info_type_reg <= dlr_pkg::INFO_TYPE_RST;
            start_chk_reg <= dlr_pkg::START_CHK_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dlr_pkg::REG_END_BYTE:  end_byte_reg  <= cfg_data;
                dlr_pkg::REG_END_TYPE:  end_type_reg  <= cfg_data[dlr_pkg::TYPE_W-1:0];
                dlr_pkg::REG_INFO_TYPE: info_type_reg <= cfg_data[dlr_pkg::TYPE_W-1:0];
                dlr_pkg::REG_START_CHK: start_chk_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // input beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_full_reg <= 1'b0;
        else if (in_accept)
            in_full_reg <= 1'b1;
        else if (advance)
            in_full_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            rx_reg    <= rx_byte;
            speed_reg <= speed_cmd;
            steer_reg <= steer_cmd;
        end
    end

    // parser state and packet serializer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            prev_reg    <= '0;
            type_reg    <= '0;
            type_ok_reg <= 1'b0;
            kind_reg    <= dlr_pkg::PKT_NONE;
            idx_reg     <= '0;
        end
        else
        begin
            if (advance)
            begin
                running_reg <= running_next;
                prev_reg    <= prev_next;
                type_reg    <= type_next;
                type_ok_reg <= type_ok_next;
                kind_reg    <= kind_next;
                idx_reg     <= '0;
            end
            else if (pkt_done)
            begin
                kind_reg <= dlr_pkg::PKT_NONE;
                idx_reg  <= '0;
            end
            else if (pkt_busy && !out_stall)
            begin
                idx_reg <= idx_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && kind_next == dlr_pkg::PKT_INFO)
        begin
            s_reg   <= s_next;
            d_reg   <= d_next;
            chk_reg <= chk_next;
        end
    end

    // byte select for the current beat
    always_comb
    begin
        tx_byte = end_byte_reg;
        if (kind_reg == dlr_pkg::PKT_POWERUP)
        begin
            if (idx_reg != dlr_pkg::POWERUP_LAST)
                tx_byte = dlr_pkg::powerup_byte(idx_reg);
        end
        else
        begin
            case (idx_reg)
                4'd0:    tx_byte = dlr_pkg::INFO_HEAD;
                4'd1:    tx_byte = {1'b1, s_reg[9:3]};
                4'd2:    tx_byte = {1'b1, d_reg[9:3]};
                4'd3:    tx_byte = dlr_pkg::INFO_POT;
                4'd4:    tx_byte = {2'b10, s_reg[2:0], d_reg[2:0]};
                4'd5:    tx_byte = dlr_pkg::INFO_STATUS;
                4'd6:    tx_byte = dlr_pkg::INFO_MODE;
                4'd7:    tx_byte = {1'b1, chk_reg};
                default: tx_byte = end_byte_reg;
            endcase
        end
    end

    assign out_valid      = pkt_busy;
    assign last_of_packet = pkt_busy && (idx_reg == last_idx);

    `ASSERT_CLK(a_idx_range, (pkt_busy |-> idx_reg <= last_idx), "packet byte index past end")
    `ASSERT_ALWAYS(a_last_valid, (last_of_packet |-> out_valid), "last flag without beat")
    `ASSERT_CLK(a_empty_flows, ((in_full_reg && !pkt_busy) |-> !in_stall), "idle serializer stalls input")
    `ASSERT_CLK(a_running_holds, (running_reg |=> running_reg), "left running phase without reset")

endmodule
